[hw/rtl/plic_pkg.sv]
`timescale 1ns / 1ps

package plic_pkg;

  // Number of interrupt sources, numbered 1..Sources; source 0 does not exist.
  localparam int Sources = 31;

  // Bits needed to hold a source id, and the leaf count of the claim tree.
  localparam int IdW    = $clog2(Sources + 1);
  localparam int Leaves = 2 ** IdW;

  localparam int PrioW = 3;

  // Operation codes.
  localparam logic [1:0] OpRead   = 2'd0;
  localparam logic [1:0] OpWrite  = 2'd1;
  localparam logic [1:0] OpUpdate = 2'd2;

  // Address map (byte offsets).
  localparam logic [21:0] PrioLimit     = 22'h001000;
  localparam logic [21:0] PendingAddr   = 22'h001000;
  localparam logic [21:0] EnableAddr    = 22'h002000;
  localparam logic [21:0] ThresholdAddr = 22'h200000;
  localparam logic [21:0] ClaimAddr     = 22'h200004;

  // One node of the claim selection tree.
  typedef struct packed {
    logic             vld;
    logic [PrioW-1:0] pri;
    logic [IdW-1:0]   id;
  } node_t;

endpackage

[hw/rtl/platform_interrupt_controller_core.sv]
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// -------  --------------------  --------------------------------------------------
// input    in_valid / in_stall   operation, address, write_data, source_levels
// output   out_valid / out_stall read_data, irq_request
//
// Every accepted item gives exactly one result item: it is held in the input
// register, where it is decoded, applied to the register file and the claim is
// resolved, then in the output register. A new item can be accepted in every
// cycle in which in_stall is low. Reset (rst, synchronous) clears all controller
// state and empties both pipeline registers. When out_stall holds a result, the
// input register keeps its item and in_stall rises only once it cannot move on.

module platform_interrupt_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [21:0] address,
  input  logic [31:0] write_data,
  input  logic [31:0] source_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        irq_request
);

  // Input register.
  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [21:0] s1_addr;
  logic [31:0] s1_wdata;
  logic [31:0] s1_levels;

  // Controller state; bit vectors are indexed by source id.
  logic [plic_pkg::PrioW-1:0] prio [1:plic_pkg::Sources];
  logic [plic_pkg::Sources:1] enable;
  logic [plic_pkg::Sources:1] pending;
  logic [plic_pkg::PrioW-1:0] threshold;
  logic [plic_pkg::Sources:1] last_levels;

  logic [plic_pkg::PrioW-1:0] prio_next [1:plic_pkg::Sources];
  logic [plic_pkg::Sources:1] enable_next;
  logic [plic_pkg::Sources:1] pending_next;
  logic [plic_pkg::PrioW-1:0] threshold_next;
  logic [plic_pkg::Sources:1] last_levels_next;

  logic        advance;
  logic        in_accept;
  logic [31:0] rd_next;
  logic        irq_next;

  // Address decode of the item held in the input register.
  logic                     is_prio;
  logic [9:0]               src;
  logic                     src_ok;
  logic [4:0]               cid;
  logic                     cid_ok;
  logic [plic_pkg::IdW-1:0] winner;

  plic_pkg::node_t tree [plic_pkg::IdW+1][plic_pkg::Leaves];

  // The item in the input register moves on whenever the output register is
  // free or is being emptied in this cycle.
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  assign is_prio = s1_addr < plic_pkg::PrioLimit;
  assign src     = s1_addr[11:2];
  assign src_ok  = (src != 10'd0) && (src <= 10'(plic_pkg::Sources));
  assign cid     = s1_wdata[4:0];
  assign cid_ok  = (cid != 5'd0) && (cid <= 5'(plic_pkg::Sources));

  // Claim selection on the current state. Leaves are ordered by id, so when
  // two candidates share a priority the right-hand (higher id) one is kept.
  always_comb begin
    tree = '{default: '0};
    for (int i = 1; i <= plic_pkg::Sources; i++) begin
      tree[0][i].vld = enable[i] && pending[i] && (prio[i] > threshold);
      tree[0][i].pri = prio[i];
      tree[0][i].id  = plic_pkg::IdW'(i);
    end
    for (int l = 1; l <= plic_pkg::IdW; l++) begin
      for (int j = 0; j < (plic_pkg::Leaves >> l); j++) begin
        if (tree[l-1][2*j+1].vld &&
            (!tree[l-1][2*j].vld || tree[l-1][2*j+1].pri >= tree[l-1][2*j].pri)) begin
          tree[l][j] = tree[l-1][2*j+1];
        end else begin
          tree[l][j] = tree[l-1][2*j];
        end
      end
    end
    winner = tree[plic_pkg::IdW][0].vld ? tree[plic_pkg::IdW][0].id : '0;
  end

  // Bus access or level update: read data and the state after this item.
  always_comb begin
    prio_next        = prio;
    enable_next      = enable;
    pending_next     = pending;
    threshold_next   = threshold;
    last_levels_next = last_levels;
    rd_next          = '0;

    case (s1_op)
      plic_pkg::OpRead: begin
        if (is_prio) begin
          if (src_ok) begin
            rd_next = 32'(prio[src[plic_pkg::IdW-1:0]]);
          end
        end else if (s1_addr == plic_pkg::PendingAddr) begin
          rd_next = 32'({pending, 1'b0});
        end else if (s1_addr == plic_pkg::EnableAddr) begin
          rd_next = 32'({enable, 1'b0});
        end else if (s1_addr == plic_pkg::ThresholdAddr) begin
          rd_next = 32'(threshold);
        end else if (s1_addr == plic_pkg::ClaimAddr) begin
          // A claim read leaves the pending bits alone.
          rd_next = 32'(winner);
        end
      end
      plic_pkg::OpWrite: begin
        if (is_prio) begin
          if (src_ok) begin
            prio_next[src[plic_pkg::IdW-1:0]] = s1_wdata[plic_pkg::PrioW-1:0];
          end
        end else if (s1_addr == plic_pkg::EnableAddr) begin
          enable_next = s1_wdata[plic_pkg::Sources:1];
        end else if (s1_addr == plic_pkg::ThresholdAddr) begin
          threshold_next = s1_wdata[plic_pkg::PrioW-1:0];
        end else if (s1_addr == plic_pkg::ClaimAddr) begin
          // Completion reloads the pending bit from the stored source level.
          if (cid_ok) begin
            pending_next[cid[plic_pkg::IdW-1:0]] = last_levels[cid[plic_pkg::IdW-1:0]];
          end
        end
      end
      plic_pkg::OpUpdate: begin
        // Levels only ever set pending bits.
        last_levels_next = s1_levels[plic_pkg::Sources:1];
        pending_next     = pending | s1_levels[plic_pkg::Sources:1];
      end
      default: begin
      end
    endcase
  end

  // An interrupt is requested when any source would win a claim after this item.
  always_comb begin
    irq_next = 1'b0;
    for (int i = 1; i <= plic_pkg::Sources; i++) begin
      if (enable_next[i] && pending_next[i] && (prio_next[i] > threshold_next)) begin
        irq_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op     <= operation;
      s1_addr   <= address;
      s1_wdata  <= write_data;
      s1_levels <= source_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= plic_pkg::Sources; i++) begin
        prio[i] <= '0;
      end
      enable      <= '0;
      pending     <= '0;
      threshold   <= '0;
      last_levels <= '0;
    end else if (advance) begin
      prio        <= prio_next;
      enable      <= enable_next;
      pending     <= pending_next;
      threshold   <= threshold_next;
      last_levels <= last_levels_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data   <= rd_next;
      irq_request <= irq_next;
    end
  end

endmodule
